// ===== hw/rtl/rlcsd_pkg.sv =====
`default_nettype none

package rlcsd_pkg;

    // Fixed frame geometry.
    localparam int BITS_PER_LED = 24;
    localparam int BIT_POS_W    = 6;
    localparam int TICK_W       = 16;

    // Configuration register map, indexed by word address.
    localparam int            REG_IDX_W        = 2;
    localparam logic [1:0]    REG_ZERO_HIGH    = 2'd0;
    localparam logic [1:0]    REG_ONE_HIGH     = 2'd1;
    localparam logic [1:0]    REG_BIT_PERIOD   = 2'd2;
    localparam logic [1:0]    REG_RESET_LOW    = 2'd3;

    // Register reset values.
    localparam logic [7:0]    ZERO_HIGH_RST    = 8'd30;
    localparam logic [7:0]    ONE_HIGH_RST     = 8'd80;
    localparam logic [7:0]    BIT_PERIOD_RST   = 8'd125;
    localparam logic [15:0]   RESET_LOW_RST    = 16'd30000;

    // Input operation codes.
    localparam logic          OP_COLOR         = 1'b0;
    localparam logic          OP_TICK          = 1'b1;

    // LED selector code that addresses every LED.
    localparam logic [1:0]    SEL_ALL          = 2'd2;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_RESET = 2'd1,
        PH_DATA  = 2'd2
    } phase_t;

endpackage

`default_nettype wire

// ===== hw/rtl/rgb_led_chain_serial_driver.sv =====
// Each accepted input transaction yields its result transaction in the next cycle.
// Throughput: one transaction per cycle; the single output register frees itself
// in the same cycle its result is taken, so input stalls only while a result waits.
// In the reset and data phases, every tick transaction advances the line timing by one step of the pulse counter.
// Reset (rst_n low, asynchronous) clears the colors, the frame sequencer, the
// pending refresh and the output valid, and loads the default timing registers.
`default_nettype none

module rgb_led_chain_serial_driver #(
    parameter int LED_COUNT = 2
) (
    input  wire logic        clk,
    input  wire logic        rst_n,

    // Input channel
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        op,
    input  wire logic [1:0]  led_select,
    input  wire logic [7:0]  red,
    input  wire logic [7:0]  green,
    input  wire logic [7:0]  blue,

    // Result channel
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             line_level,
    output logic             busy_res,
    output logic             frame_done,

    // Configuration port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [3:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    import rlcsd_pkg::*;

    // Number of data bits in one frame.
    localparam int TOTAL_BITS = LED_COUNT * BITS_PER_LED;

    // ------------------------------------------------------------------
    // Configuration registers. Writes land on the access cycle; reads
    // return the register selected by the word address.
    // ------------------------------------------------------------------
    logic [7:0]          zero_high_reg;
    logic [7:0]          one_high_reg;
    logic [7:0]          bit_period_reg;
    logic [TICK_W-1:0]   reset_low_reg;
    logic                cfg_write;
    logic [REG_IDX_W-1:0] cfg_index;

    assign pready    = 1'b1;
    assign cfg_write = psel & penable & pwrite & pready;
    assign cfg_index = paddr[3:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            zero_high_reg  <= ZERO_HIGH_RST;
            one_high_reg   <= ONE_HIGH_RST;
            bit_period_reg <= BIT_PERIOD_RST;
            reset_low_reg  <= RESET_LOW_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_ZERO_HIGH:  zero_high_reg  <= pwdata[7:0];
                REG_ONE_HIGH:   one_high_reg   <= pwdata[7:0];
                REG_BIT_PERIOD: bit_period_reg <= pwdata[7:0];
                REG_RESET_LOW:  reset_low_reg  <= pwdata[TICK_W-1:0];
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_index)
            REG_ZERO_HIGH:  prdata = {24'd0, zero_high_reg};
            REG_ONE_HIGH:   prdata = {24'd0, one_high_reg};
            REG_BIT_PERIOD: prdata = {24'd0, bit_period_reg};
            REG_RESET_LOW:  prdata = {16'd0, reset_low_reg};
            default:        prdata = 32'd0;
        endcase
    end

    // ------------------------------------------------------------------
    // Handshake. The result register is the only stage; a new transaction
    // is taken whenever that register is empty or being drained.
    // ------------------------------------------------------------------
    logic in_fire;
    logic out_valid_reg;
    logic line_level_reg;
    logic busy_reg;
    logic done_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign in_fire  = in_valid & ~in_stall;

    // ------------------------------------------------------------------
    // Sequencer state.
    // ------------------------------------------------------------------
    logic [23:0]          color_reg [LED_COUNT];
    logic [23:0]          color_next [LED_COUNT];
    phase_t               phase_reg, phase_next;
    logic [TICK_W-1:0]    tick_reg, tick_next;
    logic [BIT_POS_W-1:0] bit_pos_reg, bit_pos_next;
    logic                 pending_reg, pending_next;
    logic                 last_level_reg, last_level_next;

    logic                 res_level;
    logic                 res_busy;
    logic                 res_done;

    // Bit currently on the wire: which LED, and which bit of it, MSB first.
    logic [1:0]           cur_led;
    logic [4:0]           cur_offset;
    logic [4:0]           cur_index;
    logic                 cur_bit;

    always_comb
    begin
        if (bit_pos_reg >= BIT_POS_W'(2 * BITS_PER_LED))
        begin
            cur_led    = 2'd2;
            cur_offset = 5'(bit_pos_reg - BIT_POS_W'(2 * BITS_PER_LED));
        end
        else if (bit_pos_reg >= BIT_POS_W'(BITS_PER_LED))
        begin
            cur_led    = 2'd1;
            cur_offset = 5'(bit_pos_reg - BIT_POS_W'(BITS_PER_LED));
        end
        else
        begin
            cur_led    = 2'd0;
            cur_offset = 5'(bit_pos_reg);
        end
        cur_index = 5'(BITS_PER_LED - 1) - cur_offset;
        cur_bit   = 1'b0;
        for (int i = 0; i < LED_COUNT; i++)
        begin
            if (cur_led == 2'(i))
            begin
                cur_bit = color_reg[i][cur_index];
            end
        end
    end

    // Timing terms. A zero period or reset length behaves as one tick.
    logic [TICK_W-1:0]    tick_inc;
    logic [7:0]           period_eff;
    logic [TICK_W-1:0]    reset_len_eff;
    logic [7:0]           high_ticks;
    logic [BIT_POS_W-1:0] bit_pos_inc;
    logic                 color_written;

    assign tick_inc      = tick_reg + TICK_W'(1);
    assign period_eff    = (bit_period_reg == 8'd0) ? 8'd1 : bit_period_reg;
    assign reset_len_eff = (reset_low_reg == '0) ? TICK_W'(1) : reset_low_reg;
    assign high_ticks    = cur_bit ? one_high_reg : zero_high_reg;
    assign bit_pos_inc   = bit_pos_reg + BIT_POS_W'(1);

    always_comb
    begin
        color_next      = color_reg;
        phase_next      = phase_reg;
        tick_next       = tick_reg;
        bit_pos_next    = bit_pos_reg;
        pending_next    = pending_reg;
        last_level_next = last_level_reg;
        res_level       = 1'b0;
        res_busy        = 1'b0;
        res_done        = 1'b0;
        color_written   = 1'b0;

        if (op == OP_COLOR)
        begin
            // Store the color; selectors beyond the chain are dropped.
            for (int i = 0; i < LED_COUNT; i++)
            begin
                if (led_select == SEL_ALL || led_select == 2'(i))
                begin
                    color_next[i] = {red, green, blue};
                    color_written = 1'b1;
                end
            end
            if (color_written)
            begin
                if (phase_reg == PH_IDLE)
                begin
                    phase_next   = PH_RESET;
                    tick_next    = '0;
                    bit_pos_next = '0;
                end
                else
                begin
                    pending_next = 1'b1;
                end
            end
            res_level = last_level_reg;
            res_busy  = (phase_next != PH_IDLE);
        end
        else
        begin
            unique case (phase_reg)
                PH_IDLE:
                begin
                    tick_next    = '0;
                    bit_pos_next = '0;
                end
                PH_RESET:
                begin
                    // Latch period: line held low.
                    res_busy  = 1'b1;
                    tick_next = tick_inc;
                    if (tick_inc >= reset_len_eff)
                    begin
                        phase_next   = PH_DATA;
                        tick_next    = '0;
                        bit_pos_next = '0;
                    end
                end
                PH_DATA:
                begin
                    res_busy  = 1'b1;
                    res_level = (tick_reg < {8'd0, high_ticks});
                    tick_next = tick_inc;
                    if (tick_inc >= {8'd0, period_eff})
                    begin
                        tick_next    = '0;
                        bit_pos_next = bit_pos_inc;
                        if ({1'b0, bit_pos_inc} >= (BIT_POS_W+1)'(TOTAL_BITS))
                        begin
                            // Last bit period of the frame; chain a new frame
                            // if colors changed while this one was running.
                            res_done     = 1'b1;
                            bit_pos_next = '0;
                            if (pending_reg)
                            begin
                                pending_next = 1'b0;
                                phase_next   = PH_RESET;
                            end
                            else
                            begin
                                phase_next = PH_IDLE;
                            end
                        end
                    end
                end
                default:
                begin
                    phase_next   = PH_IDLE;
                    tick_next    = '0;
                    bit_pos_next = '0;
                end
            endcase
            last_level_next = res_level;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < LED_COUNT; i++)
            begin
                color_reg[i] <= '0;
            end
            phase_reg      <= PH_IDLE;
            tick_reg       <= '0;
            bit_pos_reg    <= '0;
            pending_reg    <= 1'b0;
            last_level_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            color_reg      <= color_next;
            phase_reg      <= phase_next;
            tick_reg       <= tick_next;
            bit_pos_reg    <= bit_pos_next;
            pending_reg    <= pending_next;
            last_level_reg <= last_level_next;
        end
    end

    // ------------------------------------------------------------------
    // Result register.
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (in_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            line_level_reg <= res_level;
            busy_reg       <= res_busy;
            done_reg       <= res_done;
        end
    end

    assign out_valid  = out_valid_reg;
    assign line_level = line_level_reg;
    assign busy_res   = busy_reg;
    assign frame_done = done_reg;

endmodule

`default_nettype wire
